>>> design/bldt_pkg.sv
// Package for the button long-press display timer.
// Payload word types, configuration register indexes and fixed timing constants.
// No dependencies.
`default_nettype none
package bldt_pkg;

    typedef struct packed {
        logic display_button;
        logic power_button;
        logic wake_request;
    } t_in_word;

    typedef struct packed {
        logic       display_on;
        logic       press_accepted;
        logic       release_accepted;
        logic       shutdown_request;
        logic       countdown_valid;
        logic [1:0] countdown_seconds;
        logic [6:0] countdown_progress;
        logic       power_level;
    } t_out_word;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REDRAW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    localparam int DEBOUNCE_W = 16;
    localparam int REDRAW_W   = 16;
    localparam int TIMEOUT_W  = 22;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [REDRAW_W-1:0]   REDRAW_RST   = 16'd200;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 22'd30000;

    localparam int HOLD_OFF_MS  = 3000;
    localparam int HOLD_SHOW_MS = 500;
    localparam int SEC_MS       = 1000;
    localparam int SEC2_MS      = 2 * SEC_MS;

    // remaining time fits 12 bits; remain/25 via multiply by ceil(2^17/25)
    localparam int REMAIN_W    = 12;
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = REMAIN_W + RECIP_W;
    localparam int RECIP_SHIFT = 17;
    localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
    localparam logic [PROD_W-RECIP_SHIFT-1:0] PROGRESS_FULL = 8'd100;

endpackage
`default_nettype wire

>>> design/bldt_in_if.sv
// Input channel: one tick word with raw button levels and wake request.
// Depends on bldt_pkg.
`default_nettype none
interface bldt_in_if;
    logic               valid;
    logic               ready;
    bldt_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/bldt_out_if.sv
// Output channel: one result word per tick.
// Depends on bldt_pkg.
`default_nettype none
interface bldt_out_if;
    logic                valid;
    logic                ready;
    bldt_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/button_long_press_display_timer_top.sv
// Button debounce, long-press power-off and display timeout controller.
// Depends on bldt_pkg, bldt_in_if, bldt_out_if.
//
//   channel   dir   handshake       word
//   i_in      in    valid/ready     display_button, power_button, wake_request
//   o_out     out   valid/ready     display_on ... power_level (one per tick)
//   i_cfg_*   in    write enable    debounce, redraw period, display timeout
//
// One word per cycle while o_out is ready; each word passes the input then the result register.
// All tick state is updated in the cycle a word moves from the input register to the
// result register. Synchronous active-low reset restores the default configuration and
// sets the tick state to its reset values. A stalled output holds its word; input keeps
// flowing while the input register can drain into the result register.
`default_nettype none
module button_long_press_display_timer_top #(
    parameter int TIME_WIDTH = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    bldt_in_if.sink                            i_in,
    bldt_out_if.source                         o_out,
    input  wire                                i_cfg_we,
    input  wire [bldt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [bldt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int TW = TIME_WIDTH;
    localparam int CW = (TW > bldt_pkg::TIMEOUT_W) ? TW : bldt_pkg::TIMEOUT_W;
    localparam int QW = bldt_pkg::PROD_W - bldt_pkg::RECIP_SHIFT;

    logic [bldt_pkg::DEBOUNCE_W-1:0] r_debounce;
    logic [bldt_pkg::REDRAW_W-1:0]   r_redraw;
    logic [bldt_pkg::TIMEOUT_W-1:0]  r_timeout;

    logic               r_s1_valid;
    bldt_pkg::t_in_word r_s1_data;
    logic                r_out_valid;
    bldt_pkg::t_out_word r_out_data;
    logic                s1_go;

    logic [TW-1:0] r_clock,       n_clock;
    logic          r_disp_level,  n_disp_level;
    logic [TW-1:0] r_disp_edge,   n_disp_edge;
    logic [TW-1:0] r_hold_start,  n_hold_start;
    logic          r_holding,     n_holding;
    logic [TW-1:0] r_last_report, n_last_report;
    logic          r_pwr_level,   n_pwr_level;
    logic [TW-1:0] r_pwr_edge,    n_pwr_edge;
    logic          r_disp_en,     n_disp_en;
    logic [TW-1:0] r_wake_time,   n_wake_time;

    bldt_pkg::t_out_word                n_out;
    logic [TW-1:0]                      held;
    logic [TW-1:0]                      idle;
    logic [bldt_pkg::REMAIN_W-1:0]      remain;
    logic [bldt_pkg::PROD_W-1:0]        prod;
    logic [QW-1:0]                      quot;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= bldt_pkg::DEBOUNCE_RST;
            r_redraw   <= bldt_pkg::REDRAW_RST;
            r_timeout  <= bldt_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bldt_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data[bldt_pkg::DEBOUNCE_W-1:0];
                bldt_pkg::CFG_REDRAW:   r_redraw   <= i_cfg_data[bldt_pkg::REDRAW_W-1:0];
                bldt_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign s1_go       = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_go;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_data <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_data <= n_out;
        end
    end

    // tick update
    always_comb begin
        n_clock       = r_clock + TW'(1);
        n_disp_level  = r_disp_level;
        n_disp_edge   = r_disp_edge;
        n_hold_start  = r_hold_start;
        n_holding     = r_holding;
        n_last_report = r_last_report;
        n_pwr_level   = r_pwr_level;
        n_pwr_edge    = r_pwr_edge;
        n_disp_en     = r_disp_en;
        n_wake_time   = r_wake_time;
        n_out         = '0;

        if (r_s1_data.wake_request) begin
            n_disp_en   = 1'b1;
            n_wake_time = r_clock;
        end

        if (r_s1_data.display_button != r_disp_level &&
            (r_clock - r_disp_edge) > TW'(r_debounce)) begin
            n_disp_edge  = r_clock;
            n_disp_level = r_s1_data.display_button;
            if (!r_s1_data.display_button) begin
                n_hold_start         = r_clock;
                n_holding            = 1'b1;
                n_wake_time          = r_clock;
                n_disp_en            = 1'b1;
                n_out.press_accepted = 1'b1;
            end else begin
                n_holding              = 1'b0;
                n_out.release_accepted = 1'b1;
            end
        end

        held   = r_clock - n_hold_start;
        remain = bldt_pkg::REMAIN_W'(bldt_pkg::HOLD_OFF_MS) - held[bldt_pkg::REMAIN_W-1:0];
        prod   = bldt_pkg::PROD_W'(remain) * bldt_pkg::PROD_W'(bldt_pkg::RECIP_25);
        quot   = prod[bldt_pkg::PROD_W-1:bldt_pkg::RECIP_SHIFT];

        if (n_holding) begin
            if (held >= TW'(bldt_pkg::HOLD_OFF_MS)) begin
                n_holding              = 1'b0;
                n_out.shutdown_request = 1'b1;
                n_disp_en              = 1'b1;
            end else if (held >= TW'(bldt_pkg::HOLD_SHOW_MS) &&
                         (r_clock - r_last_report) >= TW'(r_redraw)) begin
                n_last_report            = r_clock;
                n_out.countdown_valid    = 1'b1;
                n_out.countdown_progress = 7'(bldt_pkg::PROGRESS_FULL - quot);
                n_disp_en                = 1'b1;
                priority if (remain >= bldt_pkg::REMAIN_W'(bldt_pkg::SEC2_MS)) begin
                    n_out.countdown_seconds = 2'd3;
                end else if (remain >= bldt_pkg::REMAIN_W'(bldt_pkg::SEC_MS)) begin
                    n_out.countdown_seconds = 2'd2;
                end else begin
                    n_out.countdown_seconds = 2'd1;
                end
            end
        end

        if (r_s1_data.power_button != r_pwr_level &&
            (r_clock - r_pwr_edge) > TW'(r_debounce)) begin
            n_pwr_edge  = r_clock;
            n_pwr_level = r_s1_data.power_button;
        end

        // idle time wraps at the time width and is compared with the timeout at the wider width
        idle = r_clock - n_wake_time;
        if (!n_out.shutdown_request && n_disp_en &&
            CW'(idle) >= CW'(r_timeout)) begin
            n_disp_en = 1'b0;
        end

        n_out.display_on  = n_disp_en;
        n_out.power_level = n_pwr_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock       <= '0;
            r_disp_level  <= 1'b1;
            r_disp_edge   <= '0;
            r_hold_start  <= '0;
            r_holding     <= 1'b0;
            r_last_report <= '0;
            r_pwr_level   <= 1'b1;
            r_pwr_edge    <= '0;
            r_disp_en     <= 1'b1;
            r_wake_time   <= '0;
        end else if (s1_go) begin
            r_clock       <= n_clock;
            r_disp_level  <= n_disp_level;
            r_disp_edge   <= n_disp_edge;
            r_hold_start  <= n_hold_start;
            r_holding     <= n_holding;
            r_last_report <= n_last_report;
            r_pwr_level   <= n_pwr_level;
            r_pwr_edge    <= n_pwr_edge;
            r_disp_en     <= n_disp_en;
            r_wake_time   <= n_wake_time;
        end
    end

endmodule
`default_nettype wire

>>> dv/button_long_press_display_timer_top_tb.sv
// Self-checking testbench for button_long_press_display_timer_top.
// A clocked driver and monitor run the tick channels; a tick model predicts each result word.
// Depends on bldt_pkg, bldt_in_if, bldt_out_if and the top level.
`timescale 1ns / 100ps
module button_long_press_display_timer_top_tb;

    localparam logic [bldt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SPAN_MS     = bldt_pkg::HOLD_OFF_MS - bldt_pkg::HOLD_SHOW_MS;
    localparam int PCT_FULL    = 100;
    localparam int CYCLE_LIMIT = 2000000;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [bldt_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [bldt_pkg::CFG_DATA_W-1:0] cfg_data;

    bldt_in_if  in_if ();
    bldt_out_if out_if ();

    button_long_press_display_timer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // tick model state
    logic [bldt_pkg::DEBOUNCE_W-1:0] debounce_cfg = bldt_pkg::DEBOUNCE_RST;
    logic [bldt_pkg::REDRAW_W-1:0]   redraw_cfg   = bldt_pkg::REDRAW_RST;
    logic [bldt_pkg::TIMEOUT_W-1:0]  timeout_cfg  = bldt_pkg::TIMEOUT_RST;
    logic [31:0] now_ms       = '0;
    logic        disp_lvl     = 1'b1;
    logic [31:0] disp_edge_ms = '0;
    logic [31:0] hold_ms      = '0;
    logic        in_hold      = 1'b0;
    logic [31:0] report_ms    = '0;
    logic        pwr_lvl      = 1'b1;
    logic [31:0] pwr_edge_ms  = '0;
    logic        disp_en      = 1'b1;
    logic [31:0] wake_ms      = '0;

    bldt_pkg::t_in_word  tick_q [$];
    bldt_pkg::t_out_word result_q [$];
    bldt_pkg::t_out_word want;
    int unsigned words_pushed = 0;
    int unsigned words_sent   = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned n_press = 0, n_report = 0, n_shutdown = 0, n_dark = 0, n_settings = 1;
    int unsigned src_idle_pct = 0, snk_idle_pct = 0;
    int unsigned src_gap = 0, snk_gap = 0;
    logic pwr_raw = 1'b1;

    function automatic bldt_pkg::t_out_word step_tick(bldt_pkg::t_in_word w);
        bldt_pkg::t_out_word r;
        logic [31:0] held, remain;
        r = '0;
        if (w.wake_request) begin
            disp_en = 1'b1;
            wake_ms = now_ms;
        end
        if (w.display_button != disp_lvl && (now_ms - disp_edge_ms) > 32'(debounce_cfg)) begin
            disp_edge_ms = now_ms;
            if (!w.display_button) begin
                hold_ms = now_ms;
                in_hold = 1'b1;
                wake_ms = now_ms;
                disp_en = 1'b1;
                r.press_accepted = 1'b1;
            end else begin
                in_hold = 1'b0;
                r.release_accepted = 1'b1;
            end
            disp_lvl = w.display_button;
        end
        if (in_hold) begin
            held = now_ms - hold_ms;
            if (held >= bldt_pkg::HOLD_OFF_MS) begin
                in_hold = 1'b0;
                r.shutdown_request = 1'b1;
                disp_en = 1'b1;
            end else if (held >= bldt_pkg::HOLD_SHOW_MS &&
                         (now_ms - report_ms) >= 32'(redraw_cfg)) begin
                remain = bldt_pkg::HOLD_OFF_MS - held;
                report_ms = now_ms;
                r.countdown_valid    = 1'b1;
                r.countdown_seconds  = 2'(remain / bldt_pkg::SEC_MS + 1);
                r.countdown_progress = 7'(PCT_FULL - (remain * PCT_FULL) / SPAN_MS);
                disp_en = 1'b1;
            end
        end
        if (w.power_button != pwr_lvl && (now_ms - pwr_edge_ms) > 32'(debounce_cfg)) begin
            pwr_edge_ms = now_ms;
            pwr_lvl = w.power_button;
        end
        if (!r.shutdown_request && disp_en && (now_ms - wake_ms) >= 32'(timeout_cfg))
            disp_en = 1'b0;
        now_ms = now_ms + 1;
        r.display_on  = disp_en;
        r.power_level = pwr_lvl;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                want = step_tick(in_if.data);
                result_q.push_back(want);
                words_sent++;
                n_press    += 32'(want.press_accepted);
                n_report   += 32'(want.countdown_valid);
                n_shutdown += 32'(want.shutdown_request);
                n_dark     += 32'(!want.display_on);
            end
            if (!in_if.valid || in_if.ready) begin
                if (src_gap == 0 && $urandom_range(0, 99) < src_idle_pct)
                    src_gap = $urandom_range(1, 18);
                if (src_gap > 0) begin
                    src_gap--;
                    in_if.valid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    in_if.data  <= tick_q.pop_front();
                    in_if.valid <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (result_q.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatches++;
                end else begin
                    bldt_pkg::t_out_word exp_w;
                    exp_w = result_q.pop_front();
                    check_field("display_on", 32'(exp_w.display_on),
                                32'(out_if.data.display_on));
                    check_field("press_accepted", 32'(exp_w.press_accepted),
                                32'(out_if.data.press_accepted));
                    check_field("release_accepted", 32'(exp_w.release_accepted),
                                32'(out_if.data.release_accepted));
                    check_field("shutdown_request", 32'(exp_w.shutdown_request),
                                32'(out_if.data.shutdown_request));
                    check_field("countdown_valid", 32'(exp_w.countdown_valid),
                                32'(out_if.data.countdown_valid));
                    check_field("countdown_seconds", 32'(exp_w.countdown_seconds),
                                32'(out_if.data.countdown_seconds));
                    check_field("countdown_progress", 32'(exp_w.countdown_progress),
                                32'(out_if.data.countdown_progress));
                    check_field("power_level", 32'(exp_w.power_level),
                                32'(out_if.data.power_level));
                end
            end
            if (snk_gap == 0 && $urandom_range(0, 99) < snk_idle_pct)
                snk_gap = $urandom_range(1, 18);
            if (snk_gap > 0) begin
                snk_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [bldt_pkg::CFG_IDX_W-1:0] idx,
                             logic [bldt_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            bldt_pkg::CFG_DEBOUNCE: debounce_cfg = val[bldt_pkg::DEBOUNCE_W-1:0];
            bldt_pkg::CFG_REDRAW:   redraw_cfg   = val[bldt_pkg::REDRAW_W-1:0];
            bldt_pkg::CFG_TIMEOUT:  timeout_cfg  = val[bldt_pkg::TIMEOUT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(int unsigned dbnc, int unsigned redraw, int unsigned tmo);
        write_reg(bldt_pkg::CFG_DEBOUNCE, bldt_pkg::CFG_DATA_W'(dbnc));
        write_reg(bldt_pkg::CFG_REDRAW, bldt_pkg::CFG_DATA_W'(redraw));
        write_reg(bldt_pkg::CFG_TIMEOUT, bldt_pkg::CFG_DATA_W'(tmo));
        n_settings++;
    endtask

    task automatic push_tick(logic d, logic p, logic w);
        bldt_pkg::t_in_word t;
        t.display_button = d;
        t.power_button   = p;
        t.wake_request   = w;
        tick_q.push_back(t);
        words_pushed++;
    endtask

    // hold the display button at one level; the first ticks chatter
    task automatic push_run(logic d, int n, int chatter);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 39) == 0)
                pwr_raw = ~pwr_raw;
            push_tick((k < chatter) ? 1'($urandom_range(0, 1)) : d, pwr_raw,
                      $urandom_range(0, 49) == 0);
        end
    endtask

    // long hold walks the countdown through its three-second and two-second reports
    task automatic gen_phase(int unsigned budget, bit with_hold);
        int unsigned start;
        start = words_pushed;
        while (words_pushed - start < budget) begin
            case ($urandom_range(0, 9))
                0, 1, 2: push_run(1'b1, $urandom_range(1, 60), 0);
                3, 4, 5: begin
                    push_run(1'b0, $urandom_range(1, 150), $urandom_range(0, 4));
                    push_run(1'b1, $urandom_range(1, 150), $urandom_range(0, 4));
                end
                6: begin
                    push_run(1'b0, $urandom_range(450, 560), $urandom_range(0, 4));
                    push_run(1'b1, $urandom_range(20, 60), $urandom_range(0, 4));
                end
                7, 8: begin
                    repeat ($urandom_range(1, 20))
                        push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                end
                default: begin
                    pwr_raw = 1'b0;
                    push_run(1'b1, $urandom_range(50, 200), 0);
                    pwr_raw = 1'b1;
                end
            endcase
        end
        if (with_hold) begin
            push_run(1'b0, $urandom_range(1100, 1200), $urandom_range(0, 4));
            push_run(1'b1, $urandom_range(20, 80), $urandom_range(0, 4));
        end
    endtask

    task automatic wait_drained();
        while (words_sent != words_pushed || result_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("button_long_press_display_timer_top: mismatch");
        $finish;
    end

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = bldt_pkg::CFG_DEBOUNCE;
        cfg_data     = '0;
        i_rst_n      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all level combinations, quick timeout, wake, press and release
        set_timing(0, 0, 4);
        write_reg(CFG_UNUSED, '1);
        src_idle_pct = 10;
        snk_idle_pct = 10;
        for (int i = 0; i < 8; i++)
            push_tick(i[2], i[1], i[0]);
        repeat (6) push_tick(1'b1, 1'b1, 1'b0);
        push_tick(1'b1, 1'b1, 1'b1);
        repeat (3) push_tick(1'b0, 1'b1, 1'b0);
        repeat (3) push_tick(1'b1, 1'b0, 1'b0);
        repeat (2) push_tick(1'b1, 1'b1, 1'b0);
        wait_drained();

        set_timing($urandom_range(0, 80), $urandom_range(1, 100), $urandom_range(50, 3000));
        gen_phase(30, 1'b1);
        wait_drained();

        // zero lockout, zero redraw, zero timeout
        src_idle_pct = 25;
        snk_idle_pct = 0;
        set_timing(0, 0, 0);
        gen_phase(30, 1'b0);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 25;
        set_timing($urandom_range(0, 80), $urandom_range(0, 300), $urandom_range(1, 2000));
        gen_phase(30, 1'b0);
        wait_drained();

        src_idle_pct = 15;
        snk_idle_pct = 15;
        set_timing(32'hFFFF, 32'hFFFF, 32'h3FFFFF);
        write_reg(CFG_UNUSED, bldt_pkg::CFG_DATA_W'($urandom));
        gen_phase(30, 1'b0);
        wait_drained();

        src_idle_pct = 5;
        snk_idle_pct = 30;
        set_timing($urandom_range(0, 60), $urandom_range(1, 500), $urandom_range(500, 30000));
        gen_phase(30, 1'b0);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_timing($urandom_range(0, 40), $urandom_range(0, 200), $urandom_range(1, 800));
        gen_phase(30, 1'b0);
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("%0d ticks over %0d timing settings: %0d presses, %0d countdown reports,",
                 words_sent, n_settings, n_press, n_report);
        $display("%0d shutdown requests, %0d ticks with the display dark, %0d mismatches",
                 n_shutdown, n_dark, mismatches);
        if (mismatches == 0)
            $display("button_long_press_display_timer_top: match");
        else
            $display("button_long_press_display_timer_top: mismatch");
        $finish;
    end
endmodule

>>> button_long_press_display_timer_top.f
design/bldt_pkg.sv
design/bldt_in_if.sv
design/bldt_out_if.sv
design/button_long_press_display_timer_top.sv
dv/button_long_press_display_timer_top_tb.sv
